FILE: rtl/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared widths, stream word layout and the control bundle that the top level
// broadcasts to the row of recency cells.
// ----------------------------------------------------------------------------
package lrupr_pkg;

  // Fixed field widths of the stream words.
  localparam int unsigned InPageW    = 16;
  localparam int unsigned OutFrameW  = 3;
  localparam int unsigned CountW     = 32;
  localparam int unsigned CfgW       = 4;
  localparam int unsigned ExtW       = 32;

  // Output word layout, lowest bit first.
  localparam int unsigned OutBits    = 1 + OutFrameW + 1 + InPageW + CountW + CountW;
  localparam int unsigned OutDataW   = ((OutBits + 7) / 8) * 8;

  // Reset value of the frame count register.
  localparam logic [CfgW-1:0] CfgReset = 4'd8;

  // Control bundle sent to every cell in a cycle.
  typedef struct packed {
    logic cmp_en;    // compare stored page against the reference
    logic upd_en;    // apply the recency update this cycle
    logic shift_en;  // the update moves entries toward the list head
  } cell_ctrl_t;

endpackage

FILE: rtl/lrupr_cell.sv
// ----------------------------------------------------------------------------
// LRU recency cell
// One slot of the recency list: holds a frame number and the page in that
// frame, compares against the reference and takes its upper neighbor's entry
// when the list shifts.
// ----------------------------------------------------------------------------
module lrupr_cell #(
  parameter int unsigned IDX       = 0,
  parameter int unsigned FIDX_W    = 3,
  parameter int unsigned CNT_W     = 4,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lrupr_pkg::cell_ctrl_t  ctrl_i,
  input  logic [PAGE_BITS-1:0]   page_i,
  input  logic [CNT_W-1:0]       load_slot_i,
  input  logic [FIDX_W-1:0]      new_frame_i,
  input  logic                   chain_i,
  input  logic [FIDX_W-1:0]      next_frame_i,
  input  logic [PAGE_BITS-1:0]   next_page_i,
  input  logic                   next_valid_i,
  output logic                   match_o,
  output logic                   chain_o,
  output logic [FIDX_W-1:0]      frame_o,
  output logic [PAGE_BITS-1:0]   page_o,
  output logic                   valid_o
);
  import lrupr_pkg::*;

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);

  logic                 valid_q, valid_d;
  logic                 match_q, match_d;
  logic [FIDX_W-1:0]    frame_q, frame_d;
  logic [PAGE_BITS-1:0] page_q, page_d;
  logic                 do_shift, do_load;

  // The chain marks every slot at or above the one that leaves the list.
  assign chain_o  = chain_i | match_q;
  assign do_load  = ctrl_i.upd_en && (MyIdx == load_slot_i);
  assign do_shift = ctrl_i.upd_en && ctrl_i.shift_en && chain_o && (MyIdx < load_slot_i);

  // Next entry: new entry at the load slot, neighbor's entry on a shift.
  always_comb begin
    valid_d = valid_q;
    frame_d = frame_q;
    page_d  = page_q;
    match_d = match_q;
    if (ctrl_i.cmp_en) begin
      match_d = valid_q && (page_q == page_i);
    end
    if (do_load) begin
      valid_d = 1'b1;
      frame_d = new_frame_i;
      page_d  = page_i;
    end else if (do_shift) begin
      valid_d = next_valid_i;
      frame_d = next_frame_i;
      page_d  = next_page_i;
    end
  end

  // Control bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  // Entry payload.
  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
    page_q  <= page_d;
  end

  assign match_o = match_q;
  assign frame_o = frame_q;
  assign page_o  = page_q;
  assign valid_o = valid_q;

endmodule

FILE: rtl/lru_page_replacement_unit.sv
// ----------------------------------------------------------------------------
// LRU page replacement unit
// Tracks resident pages in a set of frames and replaces the least recently
// used page on a fault, using a row of recency cells.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one page reference per word (tdata[15:0]). Each
//   reference gives one result word on the master stream: hit flag, frame
//   holding the page, eviction flag and page, and saturating hit and fault
//   totals.
//   The configuration channel writes the number of frames in use (1..FRAMES;
//   0 acts as 1, larger values as FRAMES). Reset the block after changing it.
//   Timing: a reference is accepted, the cells compare it against their pages
//   in the next cycle, and then, once the result register is free, the recency
//   list shifts and the result word is registered. A new reference can be
//   accepted in that same update cycle, but not while a compare is in flight;
//   the compare and the shift of the cell row take place in separate states.
//   When the receiver stalls, the result word holds and the update of the
//   next reference waits until the word is taken.
//   Reset empties all frames, clears both totals and sets the frame count
//   to 8.
// ----------------------------------------------------------------------------
module lru_page_replacement_unit #(
  parameter int unsigned FRAMES    = 8,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Config: frames_in_use [3:0]
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lrupr_pkg::CfgW-1:0]        cfg_data_i,
  // Fields: page [15:0]
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [lrupr_pkg::InPageW-1:0]     s_axis_tdata,
  // Fields: hit [0], frame_index [3:1], evicted_valid [4], evicted_page [20:5],
  //         hit_total [52:21], fault_total [84:53], zero [87:85]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [lrupr_pkg::OutDataW-1:0]    m_axis_tdata
);
  import lrupr_pkg::*;

  localparam int unsigned FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CNT_W  = $clog2(FRAMES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_e;

  state_e                state_q, state_d;
  logic [CfgW-1:0]       cfg_q;
  logic [PAGE_BITS-1:0]  page_q, page_d;
  logic [CNT_W-1:0]      filled_q, filled_d;
  logic [CountW-1:0]     hits_q, hits_d;
  logic [CountW-1:0]     faults_q, faults_d;
  logic                  out_valid_q, out_valid_d;
  logic [OutDataW-1:0]   out_data_q, out_data_d;

  logic                  accept, out_free, upd_go;
  logic [ExtW-1:0]       in_ext;

  // Cell row signals.
  logic [FRAMES-1:0]     match_v, chain_v, valid_v;
  logic [FIDX_W-1:0]     frame_v [FRAMES];
  logic [PAGE_BITS-1:0]  page_v  [FRAMES];
  cell_ctrl_t            ctrl;

  logic                  found, fill, replace;
  logic [FIDX_W-1:0]     hit_frame, new_frame;
  logic [CNT_W-1:0]      load_slot;
  logic [7:0]            cfg8, act8, filled8;
  logic [ExtW-1:0]       frame_ext, evict_ext;

  // Handshakes.
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign upd_go        = (state_q == ST_UPD) && out_free;
  assign s_axis_tready = (state_q == ST_IDLE) || upd_go;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign in_ext = ExtW'(s_axis_tdata);

  // Active frame count, clamped to 1..FRAMES.
  assign cfg8    = 8'(cfg_q);
  assign filled8 = 8'(filled_q);
  always_comb begin
    if (cfg8 == 8'd0) begin
      act8 = 8'd1;
    end else if (cfg8 > 8'(FRAMES)) begin
      act8 = 8'(FRAMES);
    end else begin
      act8 = cfg8;
    end
  end

  // Hit lookup across the cells.
  always_comb begin
    hit_frame = '0;
    for (int i = 0; i < FRAMES; i++) begin
      hit_frame = hit_frame | (match_v[i] ? frame_v[i] : '0);
    end
  end

  assign found   = |match_v;
  assign fill    = !found && (filled8 < act8);
  assign replace = !found && !fill;

  // Entry written at the load slot and where it goes.
  always_comb begin
    if (found) begin
      new_frame = hit_frame;
    end else if (fill) begin
      new_frame = FIDX_W'(filled_q);
    end else begin
      new_frame = frame_v[0];
    end
    load_slot = fill ? filled_q : (filled_q - CNT_W'(1));
  end

  assign ctrl.cmp_en   = (state_q == ST_CMP);
  assign ctrl.upd_en   = upd_go;
  assign ctrl.shift_en = found || replace;

  // Row of recency cells, slot 0 is the least recently used.
  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    logic                 chain_in;
    logic [FIDX_W-1:0]    nxt_frame;
    logic [PAGE_BITS-1:0] nxt_page;
    logic                 nxt_valid;

    if (g == 0) begin : g_head
      assign chain_in = replace;
    end else begin : g_body
      assign chain_in = chain_v[g-1];
    end

    if (g == FRAMES - 1) begin : g_tail
      assign nxt_frame = '0;
      assign nxt_page  = '0;
      assign nxt_valid = 1'b0;
    end else begin : g_link
      assign nxt_frame = frame_v[g+1];
      assign nxt_page  = page_v[g+1];
      assign nxt_valid = valid_v[g+1];
    end

    lrupr_cell #(
      .IDX       (g),
      .FIDX_W    (FIDX_W),
      .CNT_W     (CNT_W),
      .PAGE_BITS (PAGE_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .page_i       (page_q),
      .load_slot_i  (load_slot),
      .new_frame_i  (new_frame),
      .chain_i      (chain_in),
      .next_frame_i (nxt_frame),
      .next_page_i  (nxt_page),
      .next_valid_i (nxt_valid),
      .match_o      (match_v[g]),
      .chain_o      (chain_v[g]),
      .frame_o      (frame_v[g]),
      .page_o       (page_v[g]),
      .valid_o      (valid_v[g])
    );
  end

  assign frame_ext = ExtW'(new_frame);
  assign evict_ext = ExtW'(page_v[0]);

  // Sequencer, counters and result word.
  always_comb begin
    state_d     = state_q;
    page_d      = page_q;
    filled_d    = filled_q;
    hits_d      = hits_q;
    faults_d    = faults_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    if (accept) begin
      page_d = in_ext[PAGE_BITS-1:0];
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (upd_go) begin
          if (found) begin
            if (hits_q != '1) begin
              hits_d = hits_q + CountW'(1);
            end
          end else if (faults_q != '1) begin
            faults_d = faults_q + CountW'(1);
          end
          if (fill) begin
            filled_d = filled_q + CNT_W'(1);
          end
          out_valid_d = 1'b1;
          out_data_d  = OutDataW'({faults_d, hits_d,
                                   (replace ? evict_ext[InPageW-1:0] : InPageW'(0)),
                                   replace, frame_ext[OutFrameW-1:0], found});
          state_d     = accept ? ST_CMP : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= CfgReset;
      filled_q    <= '0;
      hits_q      <= '0;
      faults_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      filled_q    <= filled_d;
      hits_q      <= hits_d;
      faults_q    <= faults_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        cfg_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    page_q     <= page_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Pages in filled frames are distinct, so at most one cell matches.
  a_match_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |-> $onehot0(match_v))
    else $error("more than one cell matched the reference");

  // The fill count never exceeds the number of cells.
  a_filled_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (8'(filled_q) <= 8'(FRAMES)))
    else $error("fill count beyond the number of frames");

  // Cells valid exactly below the fill count.
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |-> ($countones(valid_v) == int'(filled_q)))
    else $error("valid cells do not match the fill count");

  // No reference is taken while the compare is in flight.
  a_no_accept_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> !s_axis_tready)
    else $error("reference accepted during compare");

  // A result never reports both a hit and an eviction.
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_data_q[0] && out_data_q[4]))
    else $error("hit result carries an eviction");

endmodule
